// ===== design/spq_pkg.sv =====
// spq_pkg: shared types and constants for the sorted priority queue
// used by spq_cell and sorted_priority_queue; no dependencies
package spq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int KEY_W         = 32;
  localparam int CNT_W         = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

// ===== design/spq_cell.sv =====
// spq_cell: one slot of the sorted chain; compares against the key and
// shifts toward the tail on insert or toward the head on remove
// depends on spq_pkg
module spq_cell #(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  logic                            clk,
  input  spq_pkg::cell_ctl_t              ctl,
  input  logic [OCC_W-1:0]                occ,
  input  logic                            left_hit,
  input  logic signed [spq_pkg::KEY_W-1:0] left_entry,
  input  logic signed [spq_pkg::KEY_W-1:0] right_entry,
  output logic signed [spq_pkg::KEY_W-1:0] entry,
  output logic                            hit,
  output logic                            bound
);

  logic occupied;

  assign occupied = OCC_W'(IDX) < occ;
  assign hit      = occupied && (entry < ctl.key);
  assign bound    = !hit && left_hit;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!hit) begin
        entry <= bound ? ctl.key : left_entry;
      end
    end else if (ctl.rem) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== design/sorted_priority_queue.sv =====
// sorted_priority_queue: min-priority queue as a chain of sorted cells
// depends on spq_pkg and spq_cell
//
//  channel   signals                                          direction
//  command   start, command, value (busy is out)              in
//  result    done, removed_value, insert_position,             out
//            entry_count, status
//
// each word is accepted, then in the shift cycle every cell compares
// and shifts in parallel; the result strobe follows on the next edge
// busy is high during the shift cycle; a new word can be accepted while done
// strobes. reset clears state, count and done only; the receiver cannot stall
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             command,
  input  logic signed [spq_pkg::KEY_W-1:0] value,
  output logic                             done,
  output logic signed [spq_pkg::KEY_W-1:0] removed_value,
  output logic [spq_pkg::CNT_W-1:0]        insert_position,
  output logic [spq_pkg::CNT_W-1:0]        entry_count,
  output logic [1:0]                       status
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W = $clog2(QUEUE_DEPTH);

  spq_pkg::state_t state, state_next;
  logic [OCC_W-1:0] occ, occ_next;
  spq_pkg::cmd_t cmd;
  logic signed [spq_pkg::KEY_W-1:0] key;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::status_t st_next;
  logic [POS_W-1:0] pos_enc;

  logic signed [spq_pkg::KEY_W-1:0] entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] bound;

  logic full, empty, accept;

  assign full   = occ == OCC_W'(QUEUE_DEPTH);
  assign empty  = occ == '0;
  assign busy   = state == spq_pkg::S_EXEC;
  assign accept = start && !busy;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell #(
      .IDX  (i),
      .OCC_W(OCC_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .left_hit   ((i == 0) ? 1'b1 : hit[(i == 0) ? 0 : i - 1]),
      .left_entry ((i == 0) ? key : entries[(i == 0) ? 0 : i - 1]),
      .right_entry((i == QUEUE_DEPTH - 1) ? key
                   : entries[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .entry      (entries[i]),
      .hit        (hit[i]),
      .bound      (bound[i])
    );
  end

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (bound[i]) begin
        pos_enc = pos_enc | POS_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    occ_next   = occ;
    ctl.ins    = 1'b0;
    ctl.rem    = 1'b0;
    ctl.key    = key;
    st_next    = spq_pkg::ST_OK;
    case (state)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          state_next = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        state_next = spq_pkg::S_IDLE;
        if (cmd == spq_pkg::CMD_INSERT) begin
          if (full) begin
            st_next = spq_pkg::ST_FULL;
          end else begin
            ctl.ins  = 1'b1;
            occ_next = occ + OCC_W'(1);
          end
        end else begin
          if (empty) begin
            st_next = spq_pkg::ST_EMPTY;
          end else begin
            ctl.rem  = 1'b1;
            occ_next = occ - OCC_W'(1);
          end
        end
      end
      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= spq_pkg::cmd_t'(command);
      key <= value;
    end
    if (busy) begin
      removed_value   <= ctl.rem ? entries[0] : '0;
      insert_position <= ctl.ins ? spq_pkg::CNT_W'(pos_enc) : '0;
      entry_count     <= spq_pkg::CNT_W'(occ_next);
      status          <= st_next;
    end
  end

  // checks
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_one_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |-> $onehot(bound))
    else $error("insert boundary not unique");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("result strobe missing after shift cycle");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> occ == $past(occ) + OCC_W'(1))
    else $error("insert did not advance count");

  a_rem_count: assert property (@(posedge clk) disable iff (rst)
    ctl.rem |=> occ == $past(occ) - OCC_W'(1))
    else $error("remove did not reduce count");

endmodule
